// File: rtl/mia_pkg.sv
// Shared types for the multi-operation integer ALU.
`timescale 1ns / 1ps
package mia_pkg;

  typedef enum logic [4:0] {
    ACT_NOT    = 5'd0,
    ACT_LNOT   = 5'd1,
    ACT_SHL    = 5'd2,
    ACT_SHR    = 5'd3,
    ACT_ROL    = 5'd4,
    ACT_ROR    = 5'd5,
    ACT_AND    = 5'd6,
    ACT_XOR    = 5'd7,
    ACT_OR     = 5'd8,
    ACT_POW    = 5'd9,
    ACT_ROOT   = 5'd10,
    ACT_BSWAP  = 5'd11,
    ACT_BITREV = 5'd12,
    ACT_MUL    = 5'd13,
    ACT_DIV    = 5'd14,
    ACT_MOD    = 5'd15,
    ACT_ADD    = 5'd16,
    ACT_SUB    = 5'd17,
    ACT_PASS   = 5'd18
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POW_NEXT,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_ROOT_BIT,
    ST_ROOT_CHK,
    ST_ROOT_MUL,
    ST_ROOT_ADV,
    ST_DONE
  } state_e;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/mia_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, full double-width product.
`timescale 1ns / 1ps
module mia_mul #(
  parameter int W = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          x_i,
  input  logic [W-1:0]          y_i,
  output mia_pkg::unit_stat_t   stat_o,
  output logic [2*W-1:0]        prod_o
);
  import mia_pkg::*;

  localparam int CW = $clog2(W) + 1;

  logic [2*W-1:0] mcand_q, acc_q;
  logic [W-1:0]   mplier_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mcand_q  <= (2*W)'(x_i);
        mplier_q <= y_i;
        acc_q    <= '0;
        cnt_q    <= CW'(W);
        busy_q   <= 1'b1;
      end else if (busy_q) begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = acc_q;

endmodule

// File: rtl/mia_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mia_div #(
  parameter int W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        num_i,
  input  logic [W-1:0]        den_i,
  output mia_pkg::unit_stat_t stat_o,
  output logic [W-1:0]        quo_o,
  output logic [W-1:0]        rem_o
);
  import mia_pkg::*;

  localparam int CW = $clog2(W) + 1;

  logic [W-1:0]  rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    shifted, trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= num_i;
        den_q  <= den_i;
        cnt_q  <= CW'(W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/multi_op_integer_alu.sv
// Top level of the multi-operation integer ALU: sequencer, shared units, output register.
`timescale 1ns / 1ps
// One item at a time. DATA_WIDTH is a power of two from 8 to 64. Bitwise,
// shift, rotate, add/sub, reverse and pass ops finish with the accept, then
// the load of the output register. A rotate count is reduced modulo the
// width by keeping its low bits. Multiply, and divide and modulo by a nonzero
// divisor, run one pass of a bit-serial unit. Power uses the shared shift-add
// multiplier once per exponent bit to square and once more for each set bit,
// for the bits of b up to its highest set bit. Root tests each result bit by
// repeated exact multiplications, up to b of them per bit. Inputs are stalled
// while an item is in progress; a finished result sits in the output register
// and the next transfer is taken while it waits.
module multi_op_integer_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  action_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        div_zero_o
);
  import mia_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int LW  = $clog2(DW);
  localparam int NB  = DW / 8;
  localparam int NBW = $clog2(NB + 1);

  state_e        state_q, state_d;
  action_e       op_q, op_d, op_in;
  logic [DW-1:0] a_q, a_d, b_q, b_d;
  logic [DW-1:0] acc_q, acc_d, base_q, base_d, e_q, e_d;
  logic [DW-1:0] r_q, r_d, cand_q, cand_d, p_q, p_d;
  logic [LW-1:0] bit_q, bit_d, k_q, k_d;
  logic [DW-1:0] res_q, res_d;
  logic          dz_q, dz_d;
  logic          out_valid_q, out_valid_d, out_dz_q, out_dz_d;
  logic [DW-1:0] out_res_q, out_res_d;

  logic          mul_start, div_start;
  logic [DW-1:0] mul_x, mul_y, div_n, div_d;
  unit_stat_t    mul_stat, div_stat;
  logic [2*DW-1:0] prod;
  logic [DW-1:0] quo, rem;

  logic [DW-1:0] a_in, b_in, simple_res;
  logic          accept;

  assign a_in   = operand_a_i[DW-1:0];
  assign b_in   = operand_b_i[DW-1:0];
  assign op_in  = action_e'(action_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  mia_mul #(.W(DW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mul_x), .y_i(mul_y),
    .stat_o(mul_stat), .prod_o(prod)
  );

  mia_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .stat_o(div_stat), .quo_o(quo), .rem_o(rem)
  );

  // Rotate: the low count bits are the count modulo the width.
  logic [2*DW-1:0] rot_l, rot_r;
  logic [LW-1:0]   rot_cnt;
  assign rot_cnt = b_in[LW-1:0];
  assign rot_l   = {a_in, a_in} << rot_cnt;
  assign rot_r   = {a_in, a_in} >> rot_cnt;

  // Simple ops, computed combinationally straight from the input ports.
  logic [DW-1:0]  bitrev_full, bswap_full, keep_mask;
  logic [LW:0]    nbits;
  logic [NBW-1:0] nbytes;
  logic           shift_big;

  always_comb begin
    for (int j = 0; j < DW; j++) bitrev_full[j] = a_in[DW-1-j];
    bswap_full = '0;
    for (int j = 0; j < NB; j++) bswap_full[8*j +: 8] = a_in[8*(NB-1-j) +: 8];
  end

  assign shift_big = (b_in >= DW'(DW));
  assign nbits  = (b_in > DW'(DW)) ? (LW+1)'(DW) : b_in[LW:0];
  assign nbytes = (b_in > DW'(NB)) ? NBW'(NB) : b_in[NBW-1:0];

  always_comb begin
    keep_mask = '0;
    simple_res = '0;
    unique case (op_in)
      ACT_NOT:  simple_res = ~b_in;
      ACT_LNOT: simple_res = DW'(b_in == '0);
      ACT_SHL:  simple_res = shift_big ? '0 : (a_in << b_in[LW-1:0]);
      ACT_SHR:  simple_res = shift_big ? '0 : (a_in >> b_in[LW-1:0]);
      ACT_ROL:  simple_res = rot_l[2*DW-1:DW];
      ACT_ROR:  simple_res = rot_r[DW-1:0];
      ACT_AND:  simple_res = a_in & b_in;
      ACT_XOR:  simple_res = a_in ^ b_in;
      ACT_OR:   simple_res = a_in | b_in;
      ACT_ADD:  simple_res = a_in + b_in;
      ACT_SUB:  simple_res = a_in - b_in;
      ACT_PASS: simple_res = b_in;
      ACT_BITREV: begin
        keep_mask  = {DW{1'b1}} << nbits;
        simple_res = (a_in & keep_mask) |
                     ((bitrev_full >> ((LW+1)'(DW) - nbits)) & ~keep_mask);
      end
      ACT_BSWAP: begin
        keep_mask  = {DW{1'b1}} << {nbytes, 3'b000};
        simple_res = (a_in & keep_mask) |
                     ((bswap_full >> {NBW'(NB) - nbytes, 3'b000}) & ~keep_mask);
      end
      default:  simple_res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    acc_q     <= acc_d;
    base_q    <= base_d;
    e_q       <= e_d;
    r_q       <= r_d;
    cand_q    <= cand_d;
    p_q       <= p_d;
    bit_q     <= bit_d;
    k_q       <= k_d;
    res_q     <= res_d;
    dz_q      <= dz_d;
    out_res_q <= out_res_d;
    out_dz_q  <= out_dz_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    base_d      = base_q;
    e_d         = e_q;
    r_d         = r_q;
    cand_d      = cand_q;
    p_d         = p_q;
    bit_d       = bit_q;
    k_d         = k_q;
    res_d       = res_q;
    dz_d        = dz_q;
    out_res_d   = out_res_q;
    out_dz_d    = out_dz_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    mul_x       = acc_q;
    mul_y       = base_q;
    div_start   = 1'b0;
    div_n       = a_q;
    div_d       = b_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_in;
          a_d   = a_in;
          b_d   = b_in;
          res_d = simple_res;
          dz_d  = 1'b0;
          state_d = ST_DONE;
          priority case (op_in)
            ACT_MUL: begin
              mul_start = 1'b1;
              mul_x     = a_in;
              mul_y     = b_in;
              state_d   = ST_MUL;
            end
            ACT_DIV, ACT_MOD: begin
              if (b_in == '0) begin
                res_d = '0;
                dz_d  = 1'b1;
              end else begin
                div_start = 1'b1;
                div_n     = a_in;
                div_d     = b_in;
                state_d   = ST_DIV;
              end
            end
            ACT_POW: begin
              acc_d   = DW'(1);
              base_d  = a_in;
              e_d     = b_in;
              state_d = ST_POW_NEXT;
            end
            ACT_ROOT: begin
              if (a_in == '0 || b_in == '0) begin
                res_d = '0;
              end else if (b_in >= DW'(DW)) begin
                res_d = DW'(1);
              end else begin
                r_d     = '0;
                bit_d   = LW'(DW - 1);
                state_d = ST_ROOT_BIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MUL: begin
        if (mul_stat.done) begin
          res_d   = prod[DW-1:0];
          state_d = ST_DONE;
        end
      end

      ST_DIV: begin
        if (div_stat.done) begin
          priority case (op_q)
            ACT_DIV: res_d = quo;
            default: res_d = rem;
          endcase
          state_d = ST_DONE;
        end
      end

      // Square-and-multiply over the exponent bits, low bit first.
      ST_POW_NEXT: begin
        if (e_q == '0) begin
          res_d   = acc_q;
          state_d = ST_DONE;
        end else if (e_q[0]) begin
          mul_start = 1'b1;
          state_d   = ST_POW_MUL;
        end else begin
          e_d       = e_q >> 1;
          mul_start = 1'b1;
          mul_x     = base_q;
          state_d   = ST_POW_SQ;
        end
      end

      ST_POW_MUL: begin
        if (mul_stat.done) begin
          acc_d     = prod[DW-1:0];
          e_d       = e_q >> 1;
          mul_start = 1'b1;
          mul_x     = base_q;
          state_d   = ST_POW_SQ;
        end
      end

      ST_POW_SQ: begin
        mul_x = base_q;
        if (mul_stat.done) begin
          base_d  = prod[DW-1:0];
          state_d = ST_POW_NEXT;
        end
      end

      // Root: set result bits high to low; keep a bit if cand^b <= a exactly.
      ST_ROOT_BIT: begin
        cand_d  = r_q | (DW'(1) << bit_q);
        p_d     = DW'(1);
        k_d     = '0;
        state_d = ST_ROOT_CHK;
      end

      ST_ROOT_CHK: begin
        mul_x = p_q;
        mul_y = cand_q;
        if (k_q == b_q[LW-1:0]) begin
          r_d     = cand_q;
          state_d = ST_ROOT_ADV;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_ROOT_MUL;
        end
      end

      ST_ROOT_MUL: begin
        mul_x = p_q;
        mul_y = cand_q;
        if (mul_stat.done) begin
          if (prod[2*DW-1:DW] != '0 || prod[DW-1:0] > a_q) begin
            state_d = ST_ROOT_ADV;
          end else begin
            p_d     = prod[DW-1:0];
            k_d     = k_q + LW'(1);
            state_d = ST_ROOT_CHK;
          end
        end
      end

      ST_ROOT_ADV: begin
        if (bit_q == '0) begin
          res_d   = r_q;
          state_d = ST_DONE;
        end else begin
          bit_d   = bit_q - LW'(1);
          state_d = ST_ROOT_BIT;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_res_d   = res_q;
          out_dz_d    = dz_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = 64'(out_res_q);
  assign div_zero_o  = out_dz_q;

endmodule

// File: tb/multi_op_integer_alu_tb.sv
// Self-checking testbench for the multi-operation integer ALU.
`timescale 1ns / 1ps
module multi_op_integer_alu_tb;
  import mia_pkg::*;

  localparam int W = 64;
  // Idle cycles with no transfer on either side before the run is called hung.
  // The slowest items here are roots of a small degree.
  localparam int IDLE_LIMIT = 400000;
  localparam int NUM_RANDOM = 1825;
  localparam int FILL_HOLD = 3000;

  typedef struct {
    logic [4:0]  action;
    logic [63:0] a;
    logic [63:0] b;
  } alu_op_t;

  typedef struct {
    logic [63:0] result;
    logic        div_zero;
  } alu_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [4:0]  action_i;
  logic [63:0] operand_a_i;
  logic [63:0] operand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_o;
  logic        div_zero_o;

  alu_op_t  op_queue[$];
  alu_res_t expected_q[$];
  int       in_xfers;
  int       out_xfers;
  int       drv_seen;
  int       drv_gap;
  int       rx_hold;
  bit       fill_done;
  int       idle_cycles;
  int       errors;
  bit       stim_ready;

  multi_op_integer_alu #(.DATA_WIDTH(W)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .div_zero_o  (div_zero_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] e);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = acc * base;
      e = e >> 1;
      base = base * base;
    end
    return acc;
  endfunction

  // Exact check of cand**e <= lim without wrapping.
  function automatic bit power_fits(logic [63:0] cand, logic [63:0] e, logic [63:0] lim);
    logic [63:0] p;
    p = 64'd1;
    for (longint unsigned k = 0; k < e; k++) begin
      if (p > lim / cand) return 1'b0;
      p = p * cand;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    if (a == 0 || b == 0) return '0;
    if (b >= W) return 64'd1;
    for (int i = W - 1; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (power_fits(cand, b, a)) r = cand;
    end
    return r;
  endfunction

  // Reverse the low n groups of g bits, keep everything above them.
  function automatic logic [63:0] reverse_low(logic [63:0] a, logic [63:0] n, int g);
    logic [63:0] maxn;
    logic [63:0] gmask;
    logic [63:0] acc;
    logic [63:0] keep;
    int          span;
    maxn = 64'(W / g);
    gmask = (64'd1 << g) - 64'd1;
    acc = '0;
    keep = '0;
    if (n > maxn) n = maxn;
    span = int'(n) * g;
    if (span < 64) keep = a & ~((64'd1 << span) - 64'd1);
    for (int k = 0; k < int'(n); k++) acc = (acc << g) | ((a >> (k * g)) & gmask);
    return acc | keep;
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t   r;
    int unsigned rot;
    logic [63:0] a;
    logic [63:0] b;
    a = op.a;
    b = op.b;
    r.result = '0;
    r.div_zero = 1'b0;
    rot = 32'(b % 64'(W));
    case (op.action)
      ACT_NOT:    r.result = ~b;
      ACT_LNOT:   r.result = (b == 0) ? 64'd1 : 64'd0;
      ACT_SHL:    r.result = (b >= W) ? 64'd0 : a << b[5:0];
      ACT_SHR:    r.result = (b >= W) ? 64'd0 : a >> b[5:0];
      ACT_ROL:    r.result = (rot == 0) ? a : ((a << rot) | (a >> (W - rot)));
      ACT_ROR:    r.result = (rot == 0) ? a : ((a >> rot) | (a << (W - rot)));
      ACT_AND:    r.result = a & b;
      ACT_XOR:    r.result = a ^ b;
      ACT_OR:     r.result = a | b;
      ACT_POW:    r.result = wrap_power(a, b);
      ACT_ROOT:   r.result = floor_root(a, b);
      ACT_BSWAP:  r.result = reverse_low(a, b, 8);
      ACT_BITREV: r.result = reverse_low(a, b, 1);
      ACT_MUL:    r.result = a * b;
      ACT_DIV: begin
        if (b == 0) r.div_zero = 1'b1;
        else r.result = a / b;
      end
      ACT_MOD: begin
        if (b == 0) r.div_zero = 1'b1;
        else r.result = a % b;
      end
      ACT_ADD:    r.result = a + b;
      ACT_SUB:    r.result = a - b;
      ACT_PASS:   r.result = b;
      default:    r.result = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2: w = 64'($urandom_range(300));
      3: w = w >> $urandom_range(63);
      4: w = 64'd1 << $urandom_range(63);
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_op(logic [4:0] act, logic [63:0] a, logic [63:0] b);
    alu_op_t op;
    op.action = act;
    op.a = a;
    op.b = b;
    op_queue.push_back(op);
  endtask

  // Random item; slow ops mostly get small exponents and degrees to bound run time.
  task automatic add_random_op();
    logic [4:0]  act;
    logic [63:0] a;
    logic [63:0] b;
    int          pick;
    pick = $urandom_range(999);
    a = rand_word();
    b = rand_word();
    if (pick < 15) begin
      act = ACT_ROOT;
      b = 64'($urandom_range(3, 0));
      if ($urandom_range(9) == 0) b = {$urandom(), $urandom()} | 64'h40;
    end else if (pick < 45) begin
      act = ACT_POW;
      if ($urandom_range(9) != 0) b = 64'($urandom_range(255));
    end else if (pick < 75) begin
      act = 5'($urandom_range(31, 19));
    end else begin
      act = 5'($urandom_range(18));
      while (act == ACT_POW || act == ACT_ROOT) act = 5'($urandom_range(18));
      if ((act inside {ACT_SHL, ACT_SHR, ACT_ROL, ACT_ROR, ACT_BSWAP, ACT_BITREV})
          && $urandom_range(3) != 0)
        b = 64'($urandom_range(70));
    end
    add_op(act, a, b);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. The transfer count from the
  // monitor tells whether the item currently offered has been taken.
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i  = 1'b0;
    action_i    = '0;
    operand_a_i = '0;
    operand_b_i = '0;
  end

  always @(negedge clk_i) begin
    alu_op_t op;
    if (rst_ni && stim_ready) begin
      if (in_valid_i && in_xfers == drv_seen) begin
        // still waiting for the transfer; hold payload
      end else begin
        drv_seen = in_xfers;
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() != 0) begin
          op = op_queue.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= op.action;
          operand_a_i <= op.a;
          operand_b_i <= op.b;
          // mostly back to back, sometimes short gaps, rarely long ones
          case ($urandom_range(19))
            0, 1, 2, 3: drv_gap = $urandom_range(3, 1);
            4:          drv_gap = $urandom_range(60, 10);
            default:    drv_gap = 0;
          endcase
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random short and long holds, plus one long hold-off after
  // a few hundred results so the sender backs up against a full block.
  // ---------------------------------------------------------------------------
  initial out_stall_i = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!fill_done && out_xfers >= 300) begin
        fill_done = 1'b1;
        rx_hold = FILL_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else begin
        case ($urandom_range(39))
          0, 1, 2, 3, 4, 5: begin
            rx_hold = $urandom_range(2);
            out_stall_i <= 1'b1;
          end
          6:       begin
            rx_hold = $urandom_range(80, 20);
            out_stall_i <= 1'b1;
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers against the oldest expectation, then
  // records the prediction for an input transfer on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alu_op_t  op;
    alu_res_t exp_r;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        out_xfers++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer: result=%h div_zero=%b",
                   $realtime, result_o, div_zero_o);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_o !== exp_r.result) begin
            $display("%0t: result mismatch: expected %h actual %h",
                     $realtime, exp_r.result, result_o);
            errors++;
          end
          if (div_zero_o !== exp_r.div_zero) begin
            $display("%0t: div_zero mismatch: expected %b actual %b",
                     $realtime, exp_r.div_zero, div_zero_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        in_xfers++;
        op.action = action_i;
        op.a = operand_a_i;
        op.b = operand_b_i;
        expected_q.push_back(alu_predict(op));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    in_xfers = 0;
    out_xfers = 0;
    drv_seen = 0;
    drv_gap = 0;
    rx_hold = 0;
    fill_done = 1'b0;
    idle_cycles = 0;
    errors = 0;
    stim_ready = 1'b0;

    // Directed: every op, extreme operands, counts at and past the width,
    // zero divisors, degenerate roots, reversal counts past the word.
    add_op(ACT_NOT, '0, '0);
    add_op(ACT_LNOT, '1, '0);
    add_op(ACT_LNOT, '1, 64'h8000_0000_0000_0000);
    add_op(ACT_SHL, '1, 64'd63);
    add_op(ACT_SHL, '1, 64'd64);
    add_op(ACT_SHR, '1, '1);
    add_op(ACT_ROL, 64'h0123_4567_89ab_cdef, 64'd0);
    add_op(ACT_ROR, 64'h0123_4567_89ab_cdef, 64'd68);
    add_op(ACT_AND, '1, 64'h5555_aaaa_0f0f_f0f0);
    add_op(ACT_XOR, '1, 64'h5555_aaaa_0f0f_f0f0);
    add_op(ACT_OR, '0, 64'h5555_aaaa_0f0f_f0f0);
    add_op(ACT_POW, '1, '1);
    add_op(ACT_POW, 64'd3, 64'd0);
    add_op(ACT_ROOT, '0, 64'd2);
    add_op(ACT_ROOT, '1, 64'd0);
    add_op(ACT_ROOT, '1, 64'd2);
    add_op(ACT_ROOT, '1, 64'd64);
    add_op(ACT_BSWAP, 64'h0123_4567_89ab_cdef, 64'd3);
    add_op(ACT_BSWAP, 64'h0123_4567_89ab_cdef, '1);
    add_op(ACT_BITREV, 64'h0123_4567_89ab_cdef, 64'd65);
    add_op(ACT_MUL, '1, '1);
    add_op(ACT_DIV, '1, '0);
    add_op(ACT_MOD, '1, '0);
    add_op(ACT_MOD, '1, 64'd7);
    add_op(ACT_ADD, '1, 64'd1);
    add_op(ACT_SUB, '0, 64'd1);
    add_op(ACT_PASS, '0, '1);
    add_op(5'd31, '1, '1);
    for (int i = 0; i < NUM_RANDOM; i++) add_random_op();
    stim_ready = 1'b1;

    wait (rst_ni);
    wait (op_queue.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
